// ----- design/ipa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_pkg: shared types for the interval partition allocator
// Transfer payload structs, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package ipa_pkg;

    localparam int TIME_W  = 20;
    localparam int TAG_W   = 16;
    localparam int STALL_W = 7;

    // Input transfer: one closed interval and its tag
    typedef struct packed {
        logic [TIME_W-1:0] interval_start;
        logic [TIME_W-1:0] interval_finish;
        logic [TAG_W-1:0]  request_tag;
    } ipa_in_t;

    // Output transfer: one allocation result
    typedef struct packed {
        logic [STALL_W-1:0] assigned_stall;
        logic [TAG_W-1:0]   tag_echo;
        logic [STALL_W-1:0] stalls_total;
        logic               overflow;
    } ipa_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } ipa_state_t;

endpackage : ipa_pkg
`default_nettype wire

// ----- design/ipa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ipa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : ipa_ram
`default_nettype wire

// ----- design/interval_partition_allocator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// interval_partition_allocator_top: greedy interval partitioning
// Assigns each interval to the earliest-free stall, a new one, or flags overflow.
// ----------------------------------------------------------------------------
// Each transfer in carries one closed interval with a tag and yields exactly
// one result transfer. The end times of opened stalls live in a RAM with a
// registered read port, and a single comparator walks them one per cycle to
// find the earliest-ending stall (lowest number wins a tie). An item is
// accepted in ST_IDLE; ST_SCAN then reads the N stalls opened so far (at most
// MAX_STALLS) through the RAM read port; ST_DECIDE writes the RAM unless it
// overflows and loads the output register. in_ready is high only between
// items. The result waits in the output register, so the next item may be
// accepted before it is taken; the decide state holds while the output
// register is still full. Stall numbers and the total are reported modulo
// 128. The RAM needs no clearing after reset: only entries of opened stalls
// are ever read.
module interval_partition_allocator_top #(
    parameter int MAX_STALLS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire ipa_pkg::ipa_in_t in_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      ipa_pkg::ipa_out_t out_data
);

    import ipa_pkg::*;

    localparam int AW = $clog2(MAX_STALLS);
    localparam int CW = $clog2(MAX_STALLS + 1);

    ipa_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     issue_reg, issue_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] best_val_reg, best_val_next;
    logic [TIME_W-1:0] start_reg, finish_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              out_valid_reg, out_valid_next;
    ipa_out_t          out_data_reg, out_data_next;

    logic              in_xfer;
    logic              slot_free;
    logic              reuse;
    logic              scan_last;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [TIME_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CW-1:0]     best_num;
    logic [CW-1:0]     new_num;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Stall numbers are one above the RAM index
    assign best_num  = CW'(best_idx_reg) + CW'(1);
    assign new_num   = count_reg + CW'(1);
    assign scan_last = (CW'(issue_reg) + CW'(1)) == count_reg;
    assign reuse     = (count_reg != '0) && (best_val_reg < start_reg);

    // End-time store
    ipa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_STALLS)
    ) u_end_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (finish_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        out_data_reg <= out_data_next;
        if (in_xfer)
        begin
            start_reg  <= in_data.interval_start;
            finish_reg <= in_data.interval_finish;
            tag_reg    <= in_data.request_tag;
        end
    end

    // Sequencer: scan for the earliest end, then decide and write back
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = best_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    issue_next = '0;
                    if (count_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data holds the entry at issue_reg
                if ((issue_reg == '0) || (rd_data < best_val_reg))
                begin
                    best_val_next = rd_data;
                    best_idx_next = issue_reg;
                end
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = issue_reg + AW'(1);
                    issue_next = issue_reg + AW'(1);
                end
            end

            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.tag_echo = tag_reg;
                    out_data_next.overflow = 1'b0;
                    if (reuse)
                    begin
                        wr_en                        = 1'b1;
                        out_data_next.assigned_stall = STALL_W'(best_num);
                        out_data_next.stalls_total   = STALL_W'(count_reg);
                    end
                    else if (count_reg < CW'(MAX_STALLS))
                    begin
                        wr_en                        = 1'b1;
                        wr_addr                      = AW'(count_reg);
                        count_next                   = new_num;
                        out_data_next.assigned_stall = STALL_W'(new_num);
                        out_data_next.stalls_total   = STALL_W'(new_num);
                    end
                    else
                    begin
                        // All stalls busy: report and leave state alone
                        out_data_next.assigned_stall = '0;
                        out_data_next.stalls_total   = STALL_W'(count_reg);
                        out_data_next.overflow       = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : interval_partition_allocator_top
`default_nettype wire

// ----- design/ipa_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_checker: port-level checks for the interval partition allocator
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module ipa_checker #(
    parameter int MAX_STALLS = 64
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire ipa_pkg::ipa_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ipa_pkg::ipa_out_t out_data
);

    import ipa_pkg::*;

    localparam bit NARROW = (MAX_STALLS < 128);

    // Busy after each accepted transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an input transfer");

    // Overflow results carry no stall
    a_ovf_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.assigned_stall == '0)
        else $error("overflow result carries a stall number");

    // Overflow only once every stall is open
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        NARROW && out_valid && out_data.overflow
        |-> out_data.stalls_total == STALL_W'(MAX_STALLS))
        else $error("overflow reported before all stalls were opened");

    // A granted stall is an opened one
    a_stall_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        NARROW && out_valid && !out_data.overflow
        |-> out_data.assigned_stall != '0
            && out_data.assigned_stall <= out_data.stalls_total)
        else $error("assigned stall outside the opened range");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

endmodule : ipa_checker

bind interval_partition_allocator_top ipa_checker #(
    .MAX_STALLS (MAX_STALLS)
) u_ipa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
